>>> sv/palette_fade_sequencer_top_assert.svh
// assertion macros for the palette fade sequencer
// no dependencies; included by modules that carry concurrent checks
`ifndef PALETTE_FADE_SEQUENCER_TOP_ASSERT_SVH
`define PALETTE_FADE_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PFS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/pfs_pkg.sv
// shared types, constants and the fade table lookup for the palette fade sequencer
// no dependencies
`timescale 1ns / 1ps

package pfs_pkg;

  localparam int unsigned FADE_STEPS_DEF = 12;
  localparam int unsigned TABLE_LEN      = 12;
  localparam int unsigned STEP_W         = 4;
  localparam int unsigned MASK_W         = 8;
  localparam int unsigned SPEED_W        = 8;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned IN_DATA_W      = 8;
  localparam int unsigned OUT_DATA_W     = 16;

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 2'd0,
    OP_FADE_IN  = 2'd1,
    OP_FADE_OUT = 2'd2
  } op_t;

  localparam logic [MASK_W-1:0] FADE_TABLE [TABLE_LEN] = '{
    8'h00, 8'h40, 8'h88, 8'h91, 8'hD2, 8'hE4,
    8'hAD, 8'hB5, 8'hB6, 8'hBE, 8'hBF, 8'hFF
  };

  localparam logic [MASK_W-1:0] MASK_FULL  = 8'hFF;
  localparam logic [MASK_W-1:0] MASK_EMPTY = 8'h00;

  // step 0 reads the first entry, steps past the end read the last
  function automatic logic [MASK_W-1:0] table_entry(input logic [STEP_W-1:0] step);
    logic [STEP_W-1:0] idx;
    idx = (step == '0) ? '0 : step - STEP_W'(1);
    if (idx >= STEP_W'(TABLE_LEN)) begin
      idx = STEP_W'(TABLE_LEN - 1);
    end
    return FADE_TABLE[idx];
  endfunction

endpackage

>>> sv/palette_fade_sequencer_top.sv
// palette fade sequencer: fade state, table lookup and output skid buffer
// depends on pfs_pkg and palette_fade_sequencer_top_assert.svh
`timescale 1ns / 1ps
`include "palette_fade_sequencer_top_assert.svh"

// One command word is taken per clock. Each word updates the fade state
// (mask, step, direction, frame counter, delay, active flag) in a single
// pass of logic; its result word goes into the output register, or into
// the skid register while the output is stalled, so the output side holds
// two words and the input keeps accepting while one result waits;
// in_tready drops only when both are full. Every command, including the
// unused op code and ticks while idle, yields exactly one result word.
module palette_fade_sequencer_top #(
  parameter int unsigned FADE_STEPS = pfs_pkg::FADE_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pfs_pkg::IN_DATA_W-1:0]       in_tdata,   // [7:0] speed
  input  logic [pfs_pkg::OP_W-1:0]            in_tuser,   // [1:0] op
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pfs_pkg::OUT_DATA_W-1:0]      out_tdata   // [7:0] color_mask, [8] fading
);

  localparam int unsigned SW = pfs_pkg::STEP_W;
  localparam logic [SW-1:0] StepTop = SW'(FADE_STEPS);
  localparam logic [SW:0]   StepEnd = (SW+1)'(FADE_STEPS + 1);

  logic                          in_accept;
  pfs_pkg::op_t                  op;
  logic [pfs_pkg::SPEED_W-1:0]   speed;

  logic [pfs_pkg::MASK_W-1:0]    mask_r, mask_nxt;
  logic [SW-1:0]                 step_r, step_nxt;
  logic                          down_r, down_nxt;
  logic [pfs_pkg::SPEED_W-1:0]   frame_r, frame_nxt;
  logic [pfs_pkg::SPEED_W-1:0]   delay_r, delay_nxt;
  logic                          active_r, active_nxt;
  logic [SW:0]                   step_wide;
  logic [pfs_pkg::OUT_DATA_W-1:0] result;

  logic                          out_v_r;
  logic [pfs_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                          skid_v_r;
  logic [pfs_pkg::OUT_DATA_W-1:0] skid_data_r;

  assign in_tready = !skid_v_r;
  assign in_accept = in_tvalid && in_tready;
  assign op        = pfs_pkg::op_t'(in_tuser);
  assign speed     = in_tdata;

  // next step on full width so both ends are visible
  always_comb begin
    if (down_r) begin
      step_wide = (step_r == '0) ? '0 : {1'b0, step_r} - (SW+1)'(1);
    end else begin
      step_wide = {1'b0, step_r} + (SW+1)'(1);
    end
  end

  always_comb begin
    mask_nxt   = mask_r;
    step_nxt   = step_r;
    down_nxt   = down_r;
    frame_nxt  = frame_r;
    delay_nxt  = delay_r;
    active_nxt = active_r;
    if (in_accept) begin
      case (op)
        pfs_pkg::OP_TICK: begin
          if (active_r) begin
            if (frame_r != '0) begin
              frame_nxt = frame_r - pfs_pkg::SPEED_W'(1);
            end else begin
              frame_nxt = delay_r;
              mask_nxt  = pfs_pkg::table_entry(step_r);
              if (step_wide == '0 || step_wide == StepEnd) begin
                active_nxt = 1'b0;
              end
              step_nxt = step_wide[SW-1:0];
            end
          end
        end
        pfs_pkg::OP_FADE_IN: begin
          if (speed == '0) begin
            mask_nxt = pfs_pkg::MASK_FULL;
          end else begin
            step_nxt   = SW'(1);
            down_nxt   = 1'b0;
            delay_nxt  = speed;
            frame_nxt  = '0;
            active_nxt = 1'b1;
          end
        end
        pfs_pkg::OP_FADE_OUT: begin
          if (speed == '0) begin
            mask_nxt = pfs_pkg::MASK_EMPTY;
          end else begin
            step_nxt   = StepTop;
            down_nxt   = 1'b1;
            delay_nxt  = speed;
            frame_nxt  = '0;
            active_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign result = {{(pfs_pkg::OUT_DATA_W - pfs_pkg::MASK_W - 1){1'b0}}, active_nxt, mask_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '0;
      step_r   <= '0;
      down_r   <= 1'b0;
      frame_r  <= '0;
      delay_r  <= '0;
      active_r <= 1'b0;
    end else begin
      mask_r   <= mask_nxt;
      step_r   <= step_nxt;
      down_r   <= down_nxt;
      frame_r  <= frame_nxt;
      delay_r  <= delay_nxt;
      active_r <= active_nxt;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (in_accept) begin
      if (!out_v_r || out_tready) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (out_v_r && out_tready) begin
      if (skid_v_r) begin
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (!out_v_r || out_tready) begin
        out_data_r <= result;
      end else begin
        skid_data_r <= result;
      end
    end else if (out_v_r && out_tready && skid_v_r) begin
      out_data_r <= skid_data_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  `PFS_ASSERT_NOW(a_skid_behind_out, skid_v_r, out_v_r)
  `PFS_ASSERT_NOW(a_step_in_range, active_r, (step_r != '0) && (step_r <= StepTop))
  `PFS_ASSERT_NEXT(a_fade_starts,
    in_accept && (op == pfs_pkg::OP_FADE_IN || op == pfs_pkg::OP_FADE_OUT) && (speed != '0),
    active_r && (frame_r == '0))
  `PFS_ASSERT_NEXT(a_idle_tick_holds_mask,
    in_accept && (op == pfs_pkg::OP_TICK) && !active_r,
    $stable(mask_r) && !active_r)

endmodule
